[design/ppci_pkg.sv]
package ppci_pkg;

    // Opcodes
    localparam logic OP_COMPOSE = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // Extra fraction bits carried through the rotation
    localparam int GUARD_BITS = 16;
    // Rotation datapath width: scaled vector plus CORDIC growth
    localparam int VEC_W = 50;
    // Sum width in the rounding stage
    localparam int SUM_W = VEC_W + 2;
    // Entries in the arctangent table
    localparam int TABLE_LEN = 24;
    // CORDIC gain compensation, Q31
    localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [15:0] a_heading;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [15:0] b_heading;
    } in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [15:0] out_heading;
        logic               saturated;
    } out_t;

    // Side data that rides alongside the rotation
    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [15:0] heading;
    } side_t;

    // Arctangent of 2^-i, 2^32 per full turn
    function automatic logic [31:0] atan_turn32(input int i);
        logic [31:0] r;
        begin
            case (i)
                0:       r = 32'h20000000;
                1:       r = 32'h12E4051E;
                2:       r = 32'h09FB385B;
                3:       r = 32'h051111D4;
                4:       r = 32'h028B0D43;
                5:       r = 32'h0145D7E1;
                6:       r = 32'h00A2F61E;
                7:       r = 32'h00517C55;
                8:       r = 32'h0028BE53;
                9:       r = 32'h00145F2F;
                10:      r = 32'h000A2F98;
                11:      r = 32'h000517CC;
                12:      r = 32'h00028BE6;
                13:      r = 32'h000145F3;
                14:      r = 32'h0000A2FA;
                15:      r = 32'h0000517D;
                16:      r = 32'h000028BE;
                17:      r = 32'h0000145F;
                18:      r = 32'h00000A30;
                19:      r = 32'h00000518;
                20:      r = 32'h0000028C;
                21:      r = 32'h00000146;
                22:      r = 32'h000000A3;
                23:      r = 32'h00000051;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

[design/planar_pose_compose_inverse.sv]
// Planar pose compose / inverse. Raise start for one cycle with an item on cmd;
// busy is always low, so an item may be issued in every clock cycle. Each item
// yields exactly one result on result, marked by a one-cycle done strobe, in
// issue order. Each item passes through a gain multiply stage, a quadrant fold
// stage, the unrolled CORDIC chain with one register per micro-rotation, and a
// rounding and clipping stage. Results cannot be held off: capture them on the
// done cycle. saturated flags a clipped position.
module planar_pose_compose_inverse #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_BITS    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ppci_pkg::in_t  cmd,
    output logic           busy,
    output logic           done,
    output ppci_pkg::out_t result
);
    import ppci_pkg::*;

    localparam int N  = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam int ZW = ANGLE_BITS + 1;
    localparam int HW = ZW + 16;
    localparam int SHL = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int SHR = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);
    localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (ANGLE_BITS - 1);
    localparam logic signed [31:0]   GAIN_S  = {1'b0, GAIN_Q31};

    // ---------------------------------------------------------------
    // Stage 1: select vector and angle, scale by the gain compensation
    // ---------------------------------------------------------------
    logic signed [32:0] vx, vy;
    logic signed [15:0] neg_heading;
    logic signed [15:0] rot_heading;
    side_t              side_s1;

    logic               v1_reg;
    logic signed [63:0] px1_reg, px1_next;
    logic signed [63:0] py1_reg, py1_next;
    logic signed [15:0] h1_reg;
    side_t              side1_reg;

    always_comb
    begin
        neg_heading = 16'(-cmd.a_heading);
        if (cmd.opcode == OP_INVERSE)
        begin
            vx          = -33'(cmd.a_x);
            vy          = -33'(cmd.a_y);
            rot_heading = neg_heading;
            side_s1.tx  = '0;
            side_s1.ty  = '0;
            side_s1.heading = neg_heading;
        end
        else
        begin
            vx          = 33'(cmd.b_x);
            vy          = 33'(cmd.b_y);
            rot_heading = cmd.a_heading;
            side_s1.tx  = cmd.a_x;
            side_s1.ty  = cmd.a_y;
            side_s1.heading = 16'(cmd.a_heading + cmd.b_heading);
        end
        px1_next = 64'(vx * GAIN_S);
        py1_next = 64'(vy * GAIN_S);
    end

    // ---------------------------------------------------------------
    // Stage 2: drop to guard precision, map angle, fold half turns
    // ---------------------------------------------------------------
    logic signed [VEC_W-1:0] sx, sy;
    logic signed [HW-1:0]    h_ext;
    logic signed [ZW-1:0]    z_map;
    logic signed [VEC_W-1:0] x2_next, y2_next;
    logic signed [ZW-1:0]    z2_next;

    logic                    v2_reg;
    logic signed [VEC_W-1:0] x2_reg, y2_reg;
    logic signed [ZW-1:0]    z2_reg;
    side_t                   side2_reg;

    always_comb
    begin
        sx    = VEC_W'(px1_reg >>> (31 - GUARD_BITS));
        sy    = VEC_W'(py1_reg >>> (31 - GUARD_BITS));
        h_ext = HW'(h1_reg);
        z_map = ZW'((h_ext <<< SHL) >>> SHR);
        if (z_map > QUARTER)
        begin
            x2_next = -sx;
            y2_next = -sy;
            z2_next = z_map - HALF;
        end
        else if (z_map < -QUARTER)
        begin
            x2_next = -sx;
            y2_next = -sy;
            z2_next = z_map + HALF;
        end
        else
        begin
            x2_next = sx;
            y2_next = sy;
            z2_next = z_map;
        end
    end

    // Advance valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
        end
    end

    // Hold front stage payloads
    always_ff @(posedge clk)
    begin
        px1_reg   <= px1_next;
        py1_reg   <= py1_next;
        h1_reg    <= rot_heading;
        side1_reg <= side_s1;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        z2_reg    <= z2_next;
        side2_reg <= side1_reg;
    end

    // ---------------------------------------------------------------
    // CORDIC chain, one micro-rotation per stage
    // ---------------------------------------------------------------
    logic                    valid_c [0:N];
    logic signed [VEC_W-1:0] x_c     [0:N];
    logic signed [VEC_W-1:0] y_c     [0:N];
    logic signed [ZW-1:0]    z_c     [0:N];
    side_t                   side_c  [0:N];

    assign valid_c[0] = v2_reg;
    assign x_c[0]     = x2_reg;
    assign y_c[0]     = y2_reg;
    assign z_c[0]     = z2_reg;
    assign side_c[0]  = side2_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        ppci_cordic_stage #(
            .ANGLE_BITS (ANGLE_BITS),
            .SHIFT      (i),
            .ATAN_TURN  (atan_turn32(i))
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_c[i]),
            .x_in      (x_c[i]),
            .y_in      (y_c[i]),
            .z_in      (z_c[i]),
            .side_in   (side_c[i]),
            .valid_out (valid_c[i+1]),
            .x_out     (x_c[i+1]),
            .y_out     (y_c[i+1]),
            .z_out     (z_c[i+1]),
            .side_out  (side_c[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Final stage: add translation, round half up, clip to 32 bits
    // ---------------------------------------------------------------
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (GUARD_BITS - 1);
    localparam int RW = SUM_W - GUARD_BITS;

    logic signed [SUM_W-1:0] sum_x, sum_y;
    logic signed [RW-1:0]    rx, ry;
    logic                    clip_x, clip_y;
    out_t                    res_next;

    logic                    done_reg;
    out_t                    res_reg;

    always_comb
    begin
        sum_x = (SUM_W'(side_c[N].tx) <<< GUARD_BITS) + SUM_W'(x_c[N]) + ROUND_HALF;
        sum_y = (SUM_W'(side_c[N].ty) <<< GUARD_BITS) + SUM_W'(y_c[N]) + ROUND_HALF;
        rx    = sum_x[SUM_W-1:GUARD_BITS];
        ry    = sum_y[SUM_W-1:GUARD_BITS];
        clip_x = (rx[RW-1:31] != {(RW-31){rx[31]}});
        clip_y = (ry[RW-1:31] != {(RW-31){ry[31]}});

        if (clip_x)
            res_next.out_x = rx[RW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        else
            res_next.out_x = rx[31:0];
        if (clip_y)
            res_next.out_y = ry[RW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        else
            res_next.out_y = ry[31:0];
        res_next.out_heading = side_c[N].heading;
        res_next.saturated   = clip_x | clip_y;
    end

    // Raise done for one cycle per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_c[N];
    end

    // Hold the result
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = res_reg;

endmodule

[design/ppci_cordic_stage.sv]
module ppci_cordic_stage #(
    parameter int          ANGLE_BITS = 16,
    parameter int          SHIFT      = 0,
    parameter logic [31:0] ATAN_TURN  = 32'h20000000
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  logic signed [ppci_pkg::VEC_W-1:0]   x_in,
    input  logic signed [ppci_pkg::VEC_W-1:0]   y_in,
    input  logic signed [ANGLE_BITS:0]          z_in,
    input  ppci_pkg::side_t                     side_in,
    output logic                                valid_out,
    output logic signed [ppci_pkg::VEC_W-1:0]   x_out,
    output logic signed [ppci_pkg::VEC_W-1:0]   y_out,
    output logic signed [ANGLE_BITS:0]          z_out,
    output ppci_pkg::side_t                     side_out
);
    import ppci_pkg::*;

    localparam int ZW = ANGLE_BITS + 1;
    // Arctangent rounded half up to the angle resolution
    localparam logic [32:0] ATAN_RND =
        {1'b0, ATAN_TURN} + (33'd1 << (31 - ANGLE_BITS));
    localparam logic signed [ZW-1:0] STEP = ZW'(ATAN_RND >> (32 - ANGLE_BITS));

    logic                    valid_reg;
    logic signed [VEC_W-1:0] x_reg, x_next;
    logic signed [VEC_W-1:0] y_reg, y_next;
    logic signed [ZW-1:0]    z_reg, z_next;
    side_t                   side_reg;
    logic signed [VEC_W-1:0] dx, dy;

    // Turn one micro-rotation towards zero residual angle
    always_comb
    begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!z_in[ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - STEP;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + STEP;
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    // Hold the stage payload
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        side_reg <= side_in;
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

[design/ppci_checker.sv]
module ppci_checker #(
    parameter int LATENCY = 19
) (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input ppci_pkg::in_t  cmd,
    input logic           busy,
    input logic           done,
    input ppci_pkg::out_t result
);
    import ppci_pkg::*;

    // Every accepted item yields its strobe after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item accepted without a result after the pipeline latency");

    // No strobe without an item taken the same latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result strobe without a matching item");

    // Compose heading is the wrapped sum of both headings
    a_compose_heading: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode == OP_COMPOSE) |-> ##LATENCY
        (result.out_heading ==
            16'($past(cmd.a_heading, LATENCY) + $past(cmd.b_heading, LATENCY))))
        else $error("compose heading mismatch");

    // Inverse heading is the wrapped negation of the first heading
    a_inverse_heading: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.opcode == OP_INVERSE) |-> ##LATENCY
        (result.out_heading == 16'(-$past(cmd.a_heading, LATENCY))))
        else $error("inverse heading mismatch");

    // A clipped result sits on a range limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturated) |->
        (result.out_x == 32'sh7FFFFFFF || result.out_x == 32'sh80000000 ||
         result.out_y == 32'sh7FFFFFFF || result.out_y == 32'sh80000000))
        else $error("saturated flag without a clipped position");

endmodule

bind planar_pose_compose_inverse ppci_checker #(
    .LATENCY (CORDIC_STAGES + 3)
) u_ppci_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
);
